@@ src/bptp_pkg.sv @@
// shared types, constants and helper functions for the bundled path tag parser
`timescale 1ns / 1ps

package bptp_pkg;

	// default sizing
	localparam int MAX_TAGS_DEF = 8;
	localparam int MAX_LEN_DEF  = 4096;

	// fixed field widths
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 13;
	localparam int CNT_W  = 4;
	localparam int TYPE_W = 3;
	localparam int KIND_W = 4;
	localparam int NUM_W  = 32;
	localparam int PFX_W  = 24;
	localparam int DFI_W  = 3;
	localparam int NUM_TAIL = 8;
	localparam int OUT_DATA_W = 64;

	// separator after reset
	localparam logic [CHAR_W-1:0] SEP_RESET = 8'h01;

	// character codes
	localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COLON   = 8'h3a;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5a;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

	// lowercased tag prefixes
	localparam logic [PFX_W-1:0] PFX_ZIP = 24'h7a6970;
	localparam logic [PFX_W-1:0] PFX_EML = 24'h656d6c;
	localparam logic [PFX_W-1:0] PFX_NSF = 24'h6e7366;
	localparam logic [PFX_W-1:0] PFX_TGZ = 24'h74677a;
	localparam logic [PFX_W-1:0] PFX_GZ  = 24'h00677a;

	// tag type codes
	localparam logic [TYPE_W-1:0] TYPE_NONE = 3'd0;
	localparam logic [TYPE_W-1:0] TYPE_ZIP  = 3'd1;
	localparam logic [TYPE_W-1:0] TYPE_EML  = 3'd2;
	localparam logic [TYPE_W-1:0] TYPE_NSF  = 3'd3;
	localparam logic [TYPE_W-1:0] TYPE_GZ   = 3'd4;
	localparam logic [TYPE_W-1:0] TYPE_TGZ  = 3'd5;

	// record kind codes
	localparam logic [KIND_W-1:0] KIND_TAG     = 4'd0;
	localparam logic [KIND_W-1:0] KIND_SUMMARY = 4'd1;
	localparam logic [KIND_W-1:0] KIND_SIZE    = 4'd2;
	localparam logic [KIND_W-1:0] KIND_ZIPPED  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_YEAR    = 4'd4;
	localparam logic [KIND_W-1:0] KIND_SECOND  = 4'd9;

	// tail value slots
	localparam logic [DFI_W-1:0] TV_SIZE   = 3'd0;
	localparam logic [DFI_W-1:0] TV_ZIPPED = 3'd1;
	localparam logic [DFI_W-1:0] TV_YEAR   = 3'd2;
	localparam logic [DFI_W-1:0] DATE_FIELDS = 3'd6;

	localparam logic [NUM_W:0] YEAR_BASE = 33'd1900;

	typedef enum logic [2:0] {
		PH_NAME,
		PH_SEP,
		PH_TAG,
		PH_SIZE,
		PH_ZIPPED,
		PH_DATE_WAIT,
		PH_DATE
	} phase_t;

	typedef logic [NUM_TAIL-1:0][NUM_W-1:0] tail_vals_t;

	// records caused by one input item
	typedef struct packed {
		logic              tag_en;
		logic [IDX_W-1:0]  tag_start;
		logic [IDX_W-1:0]  tag_len;
		logic [TYPE_W-1:0] tag_type;
		logic              sum_en;
		logic [IDX_W-1:0]  sum_pos;
		logic [CNT_W-1:0]  sum_count;
		logic              bundle;
		logic              tail;
		logic              date_began;
		tail_vals_t        tail_vals;
	} event_t;

	// tag type from length and lowercased prefix
	function automatic logic [TYPE_W-1:0] classify(
		input logic [IDX_W-1:0] len,
		input logic [PFX_W-1:0] pfx
	);
		logic [TYPE_W-1:0] t;
		t = TYPE_NONE;
		if (len == IDX_W'(3)) begin
			if (pfx == PFX_ZIP) t = TYPE_ZIP;
			else if (pfx == PFX_EML) t = TYPE_EML;
			else if (pfx == PFX_NSF) t = TYPE_NSF;
			else if (pfx == PFX_TGZ) t = TYPE_TGZ;
		end else if (len == IDX_W'(2)) begin
			if (pfx == PFX_GZ) t = TYPE_GZ;
		end
		return t;
	endfunction

	// one decimal digit step with saturation, returns {stopped, value}
	function automatic logic [NUM_W:0] take_digit(
		input logic              stopped,
		input logic [NUM_W-1:0]  acc,
		input logic [CHAR_W-1:0] c
	);
		logic [NUM_W+3:0] v;
		logic [NUM_W:0]   r;
		v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
			+ (NUM_W+4)'(c - CH_DIGIT_0);
		r = {stopped, acc};
		if (!stopped) begin
			if (c < CH_DIGIT_0 || c > CH_DIGIT_9) r = {1'b1, acc};
			else if (v[NUM_W+3:NUM_W] != 4'd0) r = {1'b0, {NUM_W{1'b1}}};
			else r = {1'b0, v[NUM_W-1:0]};
		end
		return r;
	endfunction

endpackage

@@ src/bundled_path_tag_parser_unit.sv @@
// Bundled path tag parser: splits a path string into tag, summary and tail records.
//
// Input stream: one character per item in s_tdata[7:0], s_tlast on the final
// character of the string. Output stream: one record per item; m_tuser holds
// the record kind, m_tlast marks the final record caused by one character.
// The separator character is written through cfg_we/cfg_wdata; the user
// must write it only while idle, since the block does not enforce this.
// Each character is parsed in the cycle it is accepted; its records are
// held in an event register and then leave through an output register.
// A character that causes no record, or one record, does not hold the input,
// so a string streams at one character per cycle while the receiver keeps up.
// The final character causes up to ten records (closing tag, summary, eight
// tail values), sent one per cycle while the receiver accepts them;
// s_tready stays low until the last of them moves into the output register.
// When the receiver stalls, the output register holds its record and the
// input side stops once the event register is occupied.
// Reset clears the parse state, empties both registers and sets the
// separator to code 1.
`timescale 1ns / 1ps

module bundled_path_tag_parser_unit #(
	parameter int MAX_TAGS = bptp_pkg::MAX_TAGS_DEF,
	parameter int MAX_LEN  = bptp_pkg::MAX_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration: separator_code
	input  logic                              cfg_we,
	input  logic [bptp_pkg::CHAR_W-1:0]       cfg_wdata,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bptp_pkg::CHAR_W-1:0]       s_tdata,  // [7:0] char_code
	input  logic                              s_tlast,  // last_char
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [12:0] position, [25:13] length, [28:26] type_code, [29] bundle_found,
	// [30] tail_found, [62:31] number_value, [63] zero
	output logic [bptp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [bptp_pkg::KIND_W-1:0]       m_tuser,  // [3:0] record_kind
	output logic                              m_tlast   // last_of_run
);

	logic [bptp_pkg::CHAR_W-1:0] sep_q;
	bptp_pkg::event_t            ev;
	logic                        ev_any;
	logic                        can_take;
	logic                        take;

	assign s_tready = can_take;
	assign take = s_tvalid && can_take;

	// separator register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sep_q <= bptp_pkg::SEP_RESET;
		else if (cfg_we) sep_q <= cfg_wdata;
	end

	bptp_parse #(
		.MAX_TAGS(MAX_TAGS),
		.MAX_LEN (MAX_LEN)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.c     (s_tdata),
		.last  (s_tlast),
		.sep   (sep_q),
		.ev    (ev),
		.ev_any(ev_any)
	);

	bptp_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (take && ev_any),
		.ev      (ev),
		.can_take(can_take),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

`ifndef ASSERT_OFF
	// a summary that is not last must be followed by tail records
	a_summary_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == bptp_pkg::KIND_SUMMARY && !m_tlast) |-> m_tdata[30])
		else $error("summary without tail is not last of run");

	// the seconds record always ends a run
	a_second_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == bptp_pkg::KIND_SECOND) |-> m_tlast)
		else $error("seconds record not last of run");

	// a typed tag has length two or three
	a_tag_len: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == bptp_pkg::KIND_TAG && m_tdata[28:26] != bptp_pkg::TYPE_NONE)
		|-> (m_tdata[25:13] == 13'd2 || m_tdata[25:13] == 13'd3))
		else $error("typed tag with wrong length");
`endif

endmodule

@@ src/bptp_parse.sv @@
// per-character parse state and the records each character causes
`timescale 1ns / 1ps

module bptp_parse #(
	parameter int MAX_TAGS = bptp_pkg::MAX_TAGS_DEF,
	parameter int MAX_LEN  = bptp_pkg::MAX_LEN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic [bptp_pkg::CHAR_W-1:0]   c,
	input  logic                          last,
	input  logic [bptp_pkg::CHAR_W-1:0]   sep,
	output bptp_pkg::event_t              ev,
	output logic                          ev_any
);

	bptp_pkg::phase_t                 phase_q, ph;
	logic [bptp_pkg::IDX_W-1:0]       idx_q, idx_n;
	logic [bptp_pkg::IDX_W-1:0]       ts_q, ts;
	logic [bptp_pkg::PFX_W-1:0]       tp_q, tp;
	logic [bptp_pkg::IDX_W-1:0]       base_q, base;
	logic [bptp_pkg::CNT_W-1:0]       cnt_q, cnt;
	logic [bptp_pkg::TYPE_W-1:0]      ltt_q, ltt;
	logic [bptp_pkg::NUM_W-1:0]       acc_q, acc;
	logic                             stp_q, stp;
	logic [bptp_pkg::DFI_W-1:0]       dfi_q, dfi;
	bptp_pkg::tail_vals_t             tv_q, tv;
	logic [1:0]                       flags_q, flags;
	logic [bptp_pkg::NUM_W:0]         dig;
	logic                             is_digit;
	logic [bptp_pkg::CHAR_W-1:0]      lc;
	logic                             close_en;
	logic [bptp_pkg::IDX_W-1:0]       close_at;
	logic [bptp_pkg::IDX_W-1:0]       tlen;
	logic [bptp_pkg::TYPE_W-1:0]      ttype;
	logic                             tag_ok;
	logic                             date_began;

	// next state and records for the current character
	always_comb begin
		ph = phase_q;
		ts = ts_q;
		tp = tp_q;
		base = base_q;
		cnt = cnt_q;
		ltt = ltt_q;
		acc = acc_q;
		stp = stp_q;
		dfi = dfi_q;
		tv = tv_q;
		flags = flags_q;
		close_en = 1'b0;
		close_at = idx_q;
		date_began = 1'b0;
		is_digit = (c >= bptp_pkg::CH_DIGIT_0) && (c <= bptp_pkg::CH_DIGIT_9);
		lc = (c >= bptp_pkg::CH_UPPER_A && c <= bptp_pkg::CH_UPPER_Z) ?
			c + bptp_pkg::CASE_OFFSET : c;

		// character after a separator decides tag or tail
		if (ph == bptp_pkg::PH_SEP) begin
			if (is_digit) begin
				flags[1] = 1'b1;
				acc = '0;
				stp = 1'b0;
				ph = bptp_pkg::PH_SIZE;
			end else begin
				ts = idx_q;
				tp = '0;
				ph = bptp_pkg::PH_TAG;
			end
		end else if (ph == bptp_pkg::PH_DATE_WAIT) begin
			dfi = '0;
			acc = '0;
			stp = 1'b0;
			ph = bptp_pkg::PH_DATE;
		end

		dig = bptp_pkg::take_digit(stp, acc, c);

		// main step
		unique case (ph)
			bptp_pkg::PH_NAME: begin
				if (c == sep && !last) begin
					base = idx_q;
					ph = bptp_pkg::PH_SEP;
				end
			end
			bptp_pkg::PH_TAG: begin
				if (c == sep) begin
					close_en = 1'b1;
					close_at = idx_q;
					ph = bptp_pkg::PH_NAME;
				end else if ((idx_q - ts) < bptp_pkg::IDX_W'(3)) begin
					tp = {tp[15:0], lc};
				end
			end
			bptp_pkg::PH_SIZE: begin
				if (c == sep) begin
					tv[bptp_pkg::TV_SIZE] = acc;
					acc = '0;
					stp = 1'b0;
					ph = (ltt == bptp_pkg::TYPE_ZIP) ? bptp_pkg::PH_ZIPPED :
						bptp_pkg::PH_DATE_WAIT;
				end else begin
					{stp, acc} = dig;
				end
			end
			bptp_pkg::PH_ZIPPED: begin
				if (c == sep) begin
					tv[bptp_pkg::TV_ZIPPED] = acc;
					acc = '0;
					stp = 1'b0;
					ph = bptp_pkg::PH_DATE_WAIT;
				end else begin
					{stp, acc} = dig;
				end
			end
			bptp_pkg::PH_DATE: begin
				if (c == bptp_pkg::CH_COLON) begin
					if (dfi < bptp_pkg::DATE_FIELDS) begin
						tv[bptp_pkg::DFI_W'(dfi + bptp_pkg::TV_YEAR)] = acc;
						dfi = dfi + 1'b1;
					end
					acc = '0;
					stp = 1'b0;
				end else begin
					{stp, acc} = dig;
				end
			end
			default: ;
		endcase

		// saturating character index
		idx_n = (idx_q < bptp_pkg::IDX_W'(MAX_LEN)) ? idx_q + 1'b1 :
			bptp_pkg::IDX_W'(MAX_LEN);

		// end of string closes whatever is open
		if (last) begin
			unique case (ph)
				bptp_pkg::PH_TAG: begin
					close_en = 1'b1;
					close_at = idx_n;
				end
				bptp_pkg::PH_SIZE:   tv[bptp_pkg::TV_SIZE] = acc;
				bptp_pkg::PH_ZIPPED: tv[bptp_pkg::TV_ZIPPED] = acc;
				bptp_pkg::PH_DATE_WAIT: date_began = 1'b1;
				bptp_pkg::PH_DATE: begin
					if (dfi < bptp_pkg::DATE_FIELDS)
						tv[bptp_pkg::DFI_W'(dfi + bptp_pkg::TV_YEAR)] = acc;
					date_began = 1'b1;
				end
				default: ;
			endcase
		end

		// tag close, bounded by the tag limit
		tlen = (close_at >= ts) ? close_at - ts : '0;
		ttype = bptp_pkg::classify(tlen, tp);
		tag_ok = close_en && (cnt < bptp_pkg::CNT_W'(MAX_TAGS));
		if (tag_ok) begin
			cnt = cnt + 1'b1;
			ltt = ttype;
			flags[0] = 1'b1;
		end

		ev.tag_en = tag_ok;
		ev.tag_start = ts;
		ev.tag_len = tlen;
		ev.tag_type = ttype;
		ev.sum_en = last;
		ev.sum_pos = flags[1] ? base : idx_n;
		ev.sum_count = cnt;
		ev.bundle = flags[0];
		ev.tail = flags[1];
		ev.date_began = date_began;
		ev.tail_vals = tv;
		ev_any = tag_ok || last;
	end

	// parse state, cleared after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bptp_pkg::PH_NAME;
			idx_q <= '0;
			ts_q <= '0;
			tp_q <= '0;
			base_q <= '0;
			cnt_q <= '0;
			ltt_q <= bptp_pkg::TYPE_NONE;
			acc_q <= '0;
			stp_q <= 1'b0;
			dfi_q <= '0;
			tv_q <= '0;
			flags_q <= '0;
		end else if (take) begin
			if (last) begin
				phase_q <= bptp_pkg::PH_NAME;
				idx_q <= '0;
				ts_q <= '0;
				tp_q <= '0;
				base_q <= '0;
				cnt_q <= '0;
				ltt_q <= bptp_pkg::TYPE_NONE;
				acc_q <= '0;
				stp_q <= 1'b0;
				dfi_q <= '0;
				tv_q <= '0;
				flags_q <= '0;
			end else begin
				phase_q <= ph;
				idx_q <= idx_n;
				ts_q <= ts;
				tp_q <= tp;
				base_q <= base;
				cnt_q <= cnt;
				ltt_q <= ltt;
				acc_q <= acc;
				stp_q <= stp;
				dfi_q <= dfi;
				tv_q <= tv;
				flags_q <= flags;
			end
		end
	end

endmodule

@@ src/bptp_emit.sv @@
// holds one item's records and sends them one at a time through an output register
`timescale 1ns / 1ps

module bptp_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  bptp_pkg::event_t                  ev,
	output logic                              can_take,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bptp_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [bptp_pkg::KIND_W-1:0]       m_tuser,
	output logic                              m_tlast
);

	bptp_pkg::event_t                 ev_q;
	logic                             ev_valid_q;
	logic [bptp_pkg::KIND_W-1:0]      cur_q;
	logic [bptp_pkg::KIND_W-1:0]      end_q;
	logic                             out_valid_q;
	logic [bptp_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic [bptp_pkg::KIND_W-1:0]      out_kind_q;
	logic                             out_last_q;
	logic                             out_free;
	logic                             at_end;
	logic [bptp_pkg::IDX_W-1:0]       r_pos;
	logic [bptp_pkg::IDX_W-1:0]       r_len;
	logic [bptp_pkg::TYPE_W-1:0]      r_type;
	logic                             r_bf;
	logic                             r_tf;
	logic [bptp_pkg::NUM_W-1:0]       r_num;
	logic [bptp_pkg::NUM_W:0]         year_sum;
	logic [bptp_pkg::DFI_W-1:0]       tv_sel;

	assign out_free = !out_valid_q || m_tready;
	assign at_end = (cur_q == end_q);
	assign can_take = !ev_valid_q || (at_end && out_free);

	// fields of the record at the current kind
	always_comb begin
		r_pos = '0;
		r_len = '0;
		r_type = bptp_pkg::TYPE_NONE;
		r_bf = 1'b0;
		r_tf = 1'b0;
		r_num = '0;
		tv_sel = bptp_pkg::DFI_W'(cur_q - bptp_pkg::KIND_SIZE);
		year_sum = {1'b0, ev_q.tail_vals[bptp_pkg::TV_YEAR]} + bptp_pkg::YEAR_BASE;
		unique case (cur_q)
			bptp_pkg::KIND_TAG: begin
				r_pos = ev_q.tag_start;
				r_len = ev_q.tag_len;
				r_type = ev_q.tag_type;
			end
			bptp_pkg::KIND_SUMMARY: begin
				r_pos = ev_q.sum_pos;
				r_len = bptp_pkg::IDX_W'(ev_q.sum_count);
				r_bf = ev_q.bundle;
				r_tf = ev_q.tail;
			end
			bptp_pkg::KIND_YEAR: begin
				if (!ev_q.date_began) r_num = '0;
				else if (year_sum[bptp_pkg::NUM_W]) r_num = {bptp_pkg::NUM_W{1'b1}};
				else r_num = year_sum[bptp_pkg::NUM_W-1:0];
			end
			default: r_num = ev_q.tail_vals[tv_sel];
		endcase
	end

	// record sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			cur_q <= bptp_pkg::KIND_TAG;
			end_q <= bptp_pkg::KIND_TAG;
		end else begin
			if (out_free) out_valid_q <= ev_valid_q;
			// a new item only loads when none is held or the held one is sending its final record
			if (load) begin
				ev_valid_q <= 1'b1;
				cur_q <= ev.tag_en ? bptp_pkg::KIND_TAG : bptp_pkg::KIND_SUMMARY;
				end_q <= ev.tail ? bptp_pkg::KIND_SECOND :
					(ev.sum_en ? bptp_pkg::KIND_SUMMARY : bptp_pkg::KIND_TAG);
			end else if (ev_valid_q && out_free) begin
				if (at_end) ev_valid_q <= 1'b0;
				else cur_q <= cur_q + 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load) ev_q <= ev;
		if (out_free && ev_valid_q) begin
			out_data_q <= {1'b0, r_num, r_tf, r_bf, r_type, r_len, r_pos};
			out_kind_q <= cur_q;
			out_last_q <= at_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

endmodule
